>>> rtl/ktbp_pkg.sv
// Package for the keyboard, tape and beeper port: transaction types, codes and bit masks.
`timescale 1ns / 1ps
`default_nettype none
package ktbp_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLIP  = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_TAPE_EDGE  = 3'd0,
    REG_ISSUE_TWO  = 3'd1,
    REG_BEEP_LOW   = 3'd2,
    REG_BEEP_HIGH  = 3'd3,
    REG_MIC_BOOST  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] port;
    logic [7:0]  data;
    logic [2:0]  row;
  } in_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               responded;
    logic [2:0]         border_colour;
    logic signed [15:0] beeper_level;
    logic               tape_pulse_low;
  } out_t;

  localparam int unsigned NUM_ROWS = 8;

  localparam logic [7:0] KEY_MASK    = 8'h1f;
  localparam logic [7:0] FIXED_BITS  = 8'ha0;
  localparam logic [7:0] TAPE_MASK   = 8'h40;
  localparam logic [7:0] EAR_MASK    = 8'h10;
  localparam logic [7:0] MIC_MASK    = 8'h08;
  localparam logic [7:0] ALL_ONES    = 8'hff;

  localparam logic signed [15:0] BEEP_LOW_RST  = -16'sd8192;
  localparam logic signed [15:0] BEEP_HIGH_RST = 16'sd8192;
  localparam logic signed [15:0] MIC_BOOST_RST = 16'sd1638;
  localparam logic signed [15:0] PULSE_LEVEL   = -16'sd16384;
  localparam logic signed [15:0] SAT_MAX       = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN       = 16'sh8000;

endpackage
`default_nettype wire

>>> rtl/keyboard_tape_beeper_port_top.sv
// Top level of the keyboard, tape and beeper port block.
// The result of an accepted transaction is held in the output register from the next cycle.
// Throughput: one transaction per cycle while in_stall is low; the output register is the only stage.
// in_stall rises only while a held result is stalled at the output.
// Reset (synchronous, rst_n low): key rows all released, state and levels to defaults.
`timescale 1ns / 1ps
`default_nettype none
module keyboard_tape_beeper_port_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ktbp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ktbp_pkg::out_t      out_data,
  input  wire logic           cfg_psel,
  input  wire logic           cfg_penable,
  input  wire logic           cfg_pwrite,
  input  wire logic [4:0]     cfg_paddr,
  input  wire logic [31:0]    cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  // configuration
  logic               tape_edge_r;
  logic               issue_two_r;
  logic signed [15:0] beep_low_r;
  logic signed [15:0] beep_high_r;
  logic signed [15:0] mic_boost_r;

  // block state
  logic [7:0]         key_rows_r [ktbp_pkg::NUM_ROWS];
  logic [7:0]         last_written_r;
  logic               pulse_low_r;
  logic               last_ear_r;
  logic signed [15:0] beeper_r;
  logic [2:0]         border_r;
  logic               responded_r;

  logic [7:0]         last_written_nxt;
  logic               pulse_low_nxt;
  logic               last_ear_nxt;
  logic signed [15:0] beeper_nxt;
  logic [2:0]         border_nxt;
  logic               responded_nxt;
  logic [7:0]         read_nxt;

  logic               out_valid_r;
  ktbp_pkg::out_t     out_r;

  logic               in_accept;
  logic               cfg_wr;
  ktbp_pkg::reg_idx_t cfg_idx;

  logic [7:0]         key_and;
  logic               tape_in;
  logic               ear;
  logic signed [15:0] level_sel;
  logic signed [16:0] boost_sum;
  logic signed [15:0] boost_sat;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = ktbp_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tape_edge_r <= 1'b0;
      issue_two_r <= 1'b0;
      beep_low_r  <= ktbp_pkg::BEEP_LOW_RST;
      beep_high_r <= ktbp_pkg::BEEP_HIGH_RST;
      mic_boost_r <= ktbp_pkg::MIC_BOOST_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ktbp_pkg::REG_TAPE_EDGE: tape_edge_r <= cfg_pwdata[0];
        ktbp_pkg::REG_ISSUE_TWO: issue_two_r <= cfg_pwdata[0];
        ktbp_pkg::REG_BEEP_LOW:  beep_low_r  <= cfg_pwdata[15:0];
        ktbp_pkg::REG_BEEP_HIGH: beep_high_r <= cfg_pwdata[15:0];
        ktbp_pkg::REG_MIC_BOOST: mic_boost_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ktbp_pkg::REG_TAPE_EDGE: cfg_prdata = {31'd0, tape_edge_r};
      ktbp_pkg::REG_ISSUE_TWO: cfg_prdata = {31'd0, issue_two_r};
      ktbp_pkg::REG_BEEP_LOW:  cfg_prdata = {16'd0, beep_low_r};
      ktbp_pkg::REG_BEEP_HIGH: cfg_prdata = {16'd0, beep_high_r};
      ktbp_pkg::REG_MIC_BOOST: cfg_prdata = {16'd0, mic_boost_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // handshake: the output register takes a new result whenever it is free or draining
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // keyboard rows selected by high address lines
  always_comb begin
    key_and = ktbp_pkg::ALL_ONES;
    for (int i = 0; i < ktbp_pkg::NUM_ROWS; i++) begin
      if (!in_data.port[8 + i]) key_and = key_and & key_rows_r[i];
    end
  end

  always_comb begin
    if (tape_edge_r)      tape_in = !pulse_low_r;
    else if (issue_two_r) tape_in = |(last_written_r & (ktbp_pkg::EAR_MASK |
                                                        ktbp_pkg::MIC_MASK));
    else                  tape_in = |(last_written_r & ktbp_pkg::EAR_MASK);
  end

  assign ear       = |(in_data.data & ktbp_pkg::EAR_MASK);
  assign level_sel = ear ? beep_high_r : beep_low_r;
  assign boost_sum = {level_sel[15], level_sel} + {mic_boost_r[15], mic_boost_r};
  assign boost_sat = (boost_sum[16] != boost_sum[15])
                     ? (boost_sum[16] ? ktbp_pkg::SAT_MIN : ktbp_pkg::SAT_MAX)
                     : boost_sum[15:0];

  always_comb begin
    last_written_nxt = last_written_r;
    pulse_low_nxt    = pulse_low_r;
    last_ear_nxt     = last_ear_r;
    beeper_nxt       = beeper_r;
    border_nxt       = border_r;
    responded_nxt    = responded_r;
    read_nxt         = ktbp_pkg::ALL_ONES;
    unique case (in_data.command)
      ktbp_pkg::CMD_READ: begin
        if (!in_data.port[0]) begin
          responded_nxt = 1'b1;
          read_nxt      = (key_and & ktbp_pkg::KEY_MASK) | ktbp_pkg::FIXED_BITS;
          if (tape_in) read_nxt = read_nxt | ktbp_pkg::TAPE_MASK;
          else         read_nxt = read_nxt & ~ktbp_pkg::TAPE_MASK;
        end
      end
      ktbp_pkg::CMD_WRITE: begin
        responded_nxt = !in_data.port[0];
        if (!in_data.port[0]) begin
          last_written_nxt = in_data.data;
          border_nxt       = in_data.data[2:0];
          if (!tape_edge_r && (ear != last_ear_r)) begin
            beeper_nxt   = |(in_data.data & ktbp_pkg::MIC_MASK) ? boost_sat : level_sel;
            last_ear_nxt = ear;
          end
        end
      end
      ktbp_pkg::CMD_FLIP: begin
        pulse_low_nxt = !pulse_low_r;
        beeper_nxt    = pulse_low_r ? 16'sd0 : ktbp_pkg::PULSE_LEVEL;
      end
      ktbp_pkg::CMD_LOAD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ktbp_pkg::NUM_ROWS; i++) key_rows_r[i] <= ktbp_pkg::ALL_ONES;
      last_written_r <= 8'd0;
      pulse_low_r    <= 1'b0;
      last_ear_r     <= 1'b0;
      beeper_r       <= 16'sd0;
      border_r       <= 3'd0;
      responded_r    <= 1'b0;
    end else if (in_accept) begin
      if (in_data.command == ktbp_pkg::CMD_LOAD) key_rows_r[in_data.row] <= in_data.data;
      last_written_r <= last_written_nxt;
      pulse_low_r    <= pulse_low_nxt;
      last_ear_r     <= last_ear_nxt;
      beeper_r       <= beeper_nxt;
      border_r       <= border_nxt;
      responded_r    <= responded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r.read_data      <= read_nxt;
      out_r.responded      <= responded_nxt;
      out_r.border_colour  <= border_nxt;
      out_r.beeper_level   <= beeper_nxt;
      out_r.tape_pulse_low <= pulse_low_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the keyboard, tape and beeper port block.
`timescale 1ns / 1ps
module tb_top;
  import ktbp_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 3;
  localparam int ITEMS_PER_SET  = 160;
  localparam logic [4:0] UNUSED_ADDR = 5'd20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  keyboard_tape_beeper_port_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the port state and registers
  logic [7:0]         key_row_q [NUM_ROWS];
  logic [7:0]         last_wr_q;
  logic               pulse_low_q;
  logic               ear_q;
  logic signed [15:0] beep_q;
  logic [2:0]         border_q;
  logic               resp_q;
  logic               tape_edge_cfg;
  logic               issue_two_cfg;
  logic signed [15:0] level_low_cfg;
  logic signed [15:0] level_high_cfg;
  logic signed [15:0] boost_cfg;

  out_t pending_responses[$];
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_cfg = 0;
  int   quiet_cycles = 0;
  logic holding = 1'b0;
  event start_hold;

  task automatic reset_port_model();
    for (int i = 0; i < NUM_ROWS; i++) key_row_q[i] = ALL_ONES;
    last_wr_q      = '0;
    pulse_low_q    = 1'b0;
    ear_q          = 1'b0;
    beep_q         = '0;
    border_q       = '0;
    resp_q         = 1'b0;
    tape_edge_cfg  = 1'b0;
    issue_two_cfg  = 1'b0;
    level_low_cfg  = BEEP_LOW_RST;
    level_high_cfg = BEEP_HIGH_RST;
    boost_cfg      = MIC_BOOST_RST;
  endtask

  function automatic out_t port_response(input in_t t);
    out_t r;
    logic [7:0] acc;
    logic tape;
    int sum;
    acc = ALL_ONES;
    case (t.command)
      CMD_READ: begin
        if (!t.port[0]) begin
          resp_q = 1'b1;
          for (int i = 0; i < NUM_ROWS; i++)
            if (!t.port[8 + i]) acc &= key_row_q[i];
          acc = (acc & KEY_MASK) | FIXED_BITS;
          if (tape_edge_cfg) tape = !pulse_low_q;
          else if (issue_two_cfg) tape = (last_wr_q & (EAR_MASK | MIC_MASK)) != 0;
          else tape = (last_wr_q & EAR_MASK) != 0;
          acc = tape ? (acc | TAPE_MASK) : (acc & ~TAPE_MASK);
        end
      end
      CMD_WRITE: begin
        resp_q = 1'b0;
        if (!t.port[0]) begin
          resp_q    = 1'b1;
          last_wr_q = t.data;
          border_q  = t.data[2:0];
          if (!tape_edge_cfg && ((t.data & EAR_MASK) != 0) != ear_q) begin
            ear_q = (t.data & EAR_MASK) != 0;
            sum = ear_q ? level_high_cfg : level_low_cfg;
            if ((t.data & MIC_MASK) != 0) sum += boost_cfg;
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            beep_q = sum[15:0];
          end
        end
      end
      CMD_FLIP: begin
        pulse_low_q = !pulse_low_q;
        beep_q = pulse_low_q ? PULSE_LEVEL : 16'sd0;
      end
      default: key_row_q[t.row] = t.data;
    endcase
    r.read_data      = acc;
    r.responded      = resp_q;
    r.border_colour  = border_q;
    r.beeper_level   = beep_q;
    r.tape_pulse_low = pulse_low_q;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // result checker
  always @(posedge clk) begin : response_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (pending_responses.size() == 0) begin
        note_mismatch($sformatf("unexpected result rd=%h at %0t", out_data.read_data, $realtime));
      end else begin
        want = pending_responses.pop_front();
        if (out_data.read_data !== want.read_data || out_data.responded !== want.responded ||
            out_data.border_colour !== want.border_colour ||
            out_data.beeper_level !== want.beeper_level ||
            out_data.tape_pulse_low !== want.tape_pulse_low)
          note_mismatch($sformatf({"result %0d: got rd=%h resp=%b border=%0d beep=%0d ",
            "pulse=%b, exp rd=%h resp=%b border=%0d beep=%0d pulse=%b"},
            n_checked, out_data.read_data, out_data.responded, out_data.border_colour,
            out_data.beeper_level, out_data.tape_pulse_low, want.read_data, want.responded,
            want.border_colour, want.beeper_level, want.tape_pulse_low));
      end
    end
  end

  always @(posedge clk) out_stall <= holding || ($urandom_range(99) < stall_pct);

  always begin
    @(start_hold);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_responses.push_back(port_response(item));
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [4:0] addr, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    n_cfg++;
  endtask

  task automatic apb_read(input logic [4:0] addr, output logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    val = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic signed [15:0] val);
    logic [31:0] rb;
    logic [4:0] addr;
    addr = {idx, 2'b00};
    settle();
    apb_write(addr, {{16{val[15]}}, val});
    case (idx)
      REG_TAPE_EDGE: tape_edge_cfg  = val[0];
      REG_ISSUE_TWO: issue_two_cfg  = val[0];
      REG_BEEP_LOW:  level_low_cfg  = val;
      REG_BEEP_HIGH: level_high_cfg = val;
      default:       boost_cfg      = val;
    endcase
    apb_read(addr, rb);
    if ((idx == REG_TAPE_EDGE || idx == REG_ISSUE_TWO) ? (rb[0] !== val[0]) : (rb[15:0] !== val))
      note_mismatch($sformatf("register %s read back %h, wrote %h", idx.name(), rb, val));
  endtask

  function automatic logic signed [15:0] pick_level();
    case ($urandom_range(3))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      default: return 16'($urandom_range(16'hffff));
    endcase
  endfunction

  function automatic in_t random_item();
    in_t t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) t.command = CMD_READ;
    else if (pick < 65) t.command = CMD_WRITE;
    else if (pick < 75) t.command = CMD_FLIP;
    else t.command = CMD_LOAD;
    t.port = 16'($urandom_range(16'hffff));
    if ($urandom_range(3) != 0) t.port[0] = 1'b0;
    if ($urandom_range(1) == 1) t.port[15:8] = ~(8'h01 << $urandom_range(7));
    t.data = 8'($urandom_range(255));
    t.row  = 3'($urandom_range(7));
    return t;
  endfunction

  task automatic test_port_basics();
    send_item(in_t'{CMD_READ,  16'h00fe, 8'h00, 3'd0});
    send_item(in_t'{CMD_READ,  16'hffff, 8'h00, 3'd0});
    send_item(in_t'{CMD_LOAD,  16'h0000, 8'hfe, 3'd0});
    send_item(in_t'{CMD_LOAD,  16'h0000, 8'hf5, 3'd3});
    send_item(in_t'{CMD_LOAD,  16'hffff, 8'h00, 3'd7});
    send_item(in_t'{CMD_READ,  16'hfefe, 8'h00, 3'd0});
    send_item(in_t'{CMD_READ,  16'h7ffe, 8'h00, 3'd0});
    send_item(in_t'{CMD_READ,  16'hfffe, 8'hff, 3'd7});
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h17, 3'd0});
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h10, 3'd0});
    send_item(in_t'{CMD_WRITE, 16'hff00, 8'h0f, 3'd0});
    send_item(in_t'{CMD_WRITE, 16'h00ff, 8'hff, 3'd0});
    send_item(in_t'{CMD_READ,  16'h0001, 8'h00, 3'd0});
    send_item(in_t'{CMD_READ,  16'h0000, 8'h00, 3'd0});
    send_item(in_t'{CMD_FLIP,  16'h0000, 8'h00, 3'd0});
    send_item(in_t'{CMD_FLIP,  16'hffff, 8'hff, 3'd7});
    send_item(in_t'{CMD_WRITE, 16'hfffe, 8'hff, 3'd0});
    send_item(in_t'{CMD_LOAD,  16'h0000, 8'hff, 3'd7});
  endtask

  task automatic test_tape_modes();
    set_reg(REG_ISSUE_TWO, 16'sd1);
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h08, 3'd0});
    send_item(in_t'{CMD_READ,  16'h00fe, 8'h00, 3'd0});
    set_reg(REG_TAPE_EDGE, 16'sd1);
    send_item(in_t'{CMD_READ,  16'h00fe, 8'h00, 3'd0});
    send_item(in_t'{CMD_FLIP,  16'h0000, 8'h00, 3'd0});
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h10, 3'd0});
    send_item(in_t'{CMD_READ,  16'h00fe, 8'h00, 3'd0});
    set_reg(REG_TAPE_EDGE, 16'sd0);
    set_reg(REG_ISSUE_TWO, 16'sd0);
  endtask

  task automatic test_beeper_saturation();
    set_reg(REG_BEEP_HIGH, SAT_MAX);
    set_reg(REG_BEEP_LOW,  SAT_MIN);
    set_reg(REG_MIC_BOOST, SAT_MAX);
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h18, 3'd0});
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h08, 3'd0});
    set_reg(REG_MIC_BOOST, SAT_MIN);
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h18, 3'd0});
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h08, 3'd0});
    // unmapped register: no effect
    settle();
    apb_write(UNUSED_ADDR, 32'hffff_ffff);
    send_item(in_t'{CMD_WRITE, 16'h00fe, 8'h18, 3'd0});
    set_reg(REG_BEEP_HIGH, BEEP_HIGH_RST);
    set_reg(REG_BEEP_LOW,  BEEP_LOW_RST);
    set_reg(REG_MIC_BOOST, MIC_BOOST_RST);
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int s = 0; s < 2; s++) begin
        set_reg(REG_TAPE_EDGE, 16'($urandom_range(1)));
        set_reg(REG_ISSUE_TWO, 16'($urandom_range(1)));
        set_reg(REG_BEEP_LOW,  pick_level());
        set_reg(REG_BEEP_HIGH, pick_level());
        set_reg(REG_MIC_BOOST, pick_level());
        for (int n = 0; n < ITEMS_PER_SET; n++) send_item(random_item());
      end
    end
  endtask

  task automatic test_backpressure();
    settle();
    idle_pct  = 0;
    stall_pct = 0;
    -> start_hold;
    for (int n = 0; n < 80; n++) send_item(random_item());
  endtask

  initial begin
    reset_port_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_port_basics();
    test_tape_modes();
    test_beeper_saturation();
    test_random_traffic();
    test_backpressure();
    settle();
    $display("sent %0d transactions, checked %0d results, %0d register writes",
             n_sent, n_checked, n_cfg);
    $display("covered all commands, tape modes, beeper saturation, idling and a long hold-off");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ktbp_pkg.sv
rtl/keyboard_tape_beeper_port_top.sv
sim/tb_top.sv
